@@ sv/ppa_pkg.sv @@
`default_nettype none
package ppa_pkg;

   // Fixed field widths of the block.
   localparam int COORD_WIDTH = 16;
   localparam int SUM_WIDTH   = 40;
   localparam int PERIM_WIDTH = 40;
   localparam int COUNT_WIDTH = 16;

   // Square of a coordinate difference, and the sum of two such squares.
   localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
   localparam int SSQ_WIDTH   = SQ_WIDTH + 1;
   // Fraction bits appended to the radicand before the root is taken.
   localparam int FRAC_SHIFT  = 8;
   // Root bits produced, one per iteration, and the widths that follow.
   localparam int ROOT_BITS   = (SSQ_WIDTH + FRAC_SHIFT + 1) / 2;
   localparam int RAD_WIDTH   = 2 * ROOT_BITS;
   localparam int REM_WIDTH   = ROOT_BITS + 3;
   localparam int ITER_WIDTH  = $clog2(ROOT_BITS);

   // Item codes.
   localparam logic MODE_VERTEX = 1'b0;
   localparam logic MODE_CLOSE  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;         // an input item is transferred this cycle
      logic diff_en;        // form the coordinate difference magnitudes
      logic square_en;      // square the differences
      logic load_radicand;  // build the radicand and clear the root
      logic root_step;      // one iteration of the square root
      logic accumulate;     // add the edge length to the running sum
      logic emit;           // load the result register and clear the state
   } ppa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic have_first;
   } ppa_status_type;

endpackage
`default_nettype wire

@@ sv/ppa_ctrl.sv @@
`default_nettype none
module ppa_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_mode,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire ppa_pkg::ppa_status_type     status,
   output ppa_pkg::ppa_cmd_type             cmd
);
   import ppa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_RADICAND,
      ST_ROOT,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic                  close_ff, close_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   logic                  take;
   logic                  emit;

   assign take      = req_valid && (state_ff == ST_IDLE);
   assign emit      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands follow directly from the state, the request valid and the result handshake.
   always_comb begin
      cmd               = '0;
      cmd.accept        = take;
      cmd.diff_en       = (state_ff == ST_DIFF);
      cmd.square_en     = (state_ff == ST_SQUARE);
      cmd.load_radicand = (state_ff == ST_RADICAND);
      cmd.root_step     = (state_ff == ST_ROOT);
      cmd.accumulate    = (state_ff == ST_ACCUM);
      cmd.emit          = emit;
   end

   // Next state, iteration count and result valid flag.
   always_comb begin
      state_in     = state_ff;
      close_in     = close_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               close_in = (req_mode == MODE_CLOSE);
               if (status.have_first) begin
                  state_in = ST_DIFF;
               end else if (req_mode == MODE_CLOSE) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIFF: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_RADICAND;
         end
         ST_RADICAND: begin
            iter_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            iter_in = iter_ff + ITER_WIDTH'(1);
            if (iter_ff == ITER_WIDTH'(ROOT_BITS - 1)) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = close_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         close_ff     <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         close_ff     <= close_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/ppa_datapath.sv @@
`default_nettype none
module ppa_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire ppa_pkg::ppa_cmd_type                    cmd,
   output ppa_pkg::ppa_status_type                      status,
   input  wire logic                                    req_mode,
   input  wire logic signed [ppa_pkg::COORD_WIDTH-1:0]  req_coord_x,
   input  wire logic signed [ppa_pkg::COORD_WIDTH-1:0]  req_coord_y,
   output logic [ppa_pkg::PERIM_WIDTH-1:0]              rsp_perimeter,
   output logic                                         rsp_overflow,
   output logic [ppa_pkg::COUNT_WIDTH-1:0]              rsp_vertex_count
);
   import ppa_pkg::*;

   // Polygon state.
   logic [COORD_WIDTH-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                   have_first_ff, have_first_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic                   sat_ff, sat_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // Edge length pipeline.
   logic [COORD_WIDTH-1:0] a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic [COORD_WIDTH-1:0] b_x_ff, b_x_in, b_y_ff, b_y_in;
   logic [COORD_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_WIDTH-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_WIDTH-1:0]   rad_ff, rad_in;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;

   // Result register.
   logic [PERIM_WIDTH-1:0] perim_ff, perim_in;
   logic                   ovf_ff, ovf_in;
   logic [COUNT_WIDTH-1:0] vcount_ff, vcount_in;

   logic [COORD_WIDTH:0]   diff_x, diff_y;
   logic [SSQ_WIDTH-1:0]   ssq;
   logic [REM_WIDTH-1:0]   rem_shift, trial;
   logic [SUM_WIDTH:0]     sum_ext;

   assign status.have_first = have_first_ff;
   assign rsp_perimeter     = perim_ff;
   assign rsp_overflow      = ovf_ff;
   assign rsp_vertex_count  = vcount_ff;

   // Signed differences widened by one bit, so that the magnitude always fits.
   assign diff_x = {a_x_ff[COORD_WIDTH-1], a_x_ff} - {b_x_ff[COORD_WIDTH-1], b_x_ff};
   assign diff_y = {a_y_ff[COORD_WIDTH-1], a_y_ff} - {b_y_ff[COORD_WIDTH-1], b_y_ff};

   // Sum of squares, and one restoring square root iteration.
   assign ssq       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign rem_shift = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign sum_ext   = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(root_ff);

   always_comb begin
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      have_first_in = have_first_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      count_in      = count_ff;
      a_x_in        = a_x_ff;
      a_y_in        = a_y_ff;
      b_x_in        = b_x_ff;
      b_y_in        = b_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      perim_in      = perim_ff;
      ovf_in        = ovf_ff;
      vcount_in     = vcount_ff;

      // On a transfer the edge end points are captured; a vertex also
      // updates the stored vertices and the count at once.
      if (cmd.accept) begin
         b_x_in = prev_x_ff;
         b_y_in = prev_y_ff;
         if (req_mode == MODE_CLOSE) begin
            a_x_in = first_x_ff;
            a_y_in = first_y_ff;
         end else begin
            a_x_in    = req_coord_x;
            a_y_in    = req_coord_y;
            prev_x_in = req_coord_x;
            prev_y_in = req_coord_y;
            if (!have_first_ff) begin
               first_x_in    = req_coord_x;
               first_y_in    = req_coord_y;
               have_first_in = 1'b1;
            end
            if (count_ff != {COUNT_WIDTH{1'b1}}) begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
      end

      // Difference magnitudes.
      if (cmd.diff_en) begin
         dx_in = diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
         dy_in = diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
      end

      // Squares, one multiplier each.
      if (cmd.square_en) begin
         sqx_in = dx_ff * dx_ff;
         sqy_in = dy_ff * dy_ff;
      end

      // Radicand with eight fraction bits appended.
      if (cmd.load_radicand) begin
         rad_in  = RAD_WIDTH'({ssq, {FRAC_SHIFT{1'b0}}});
         rem_in  = '0;
         root_in = '0;
      end

      // One root bit per cycle, top pair of the radicand first.
      if (cmd.root_step) begin
         rad_in = {rad_ff[RAD_WIDTH-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end

      // Saturating accumulation; the flag stays set until the close.
      if (cmd.accumulate) begin
         if (sum_ext[SUM_WIDTH]) begin
            sum_in = {SUM_WIDTH{1'b1}};
            sat_in = 1'b1;
         end else begin
            sum_in = sum_ext[SUM_WIDTH-1:0];
         end
      end

      // Result register load and return of the polygon state to its reset value.
      if (cmd.emit) begin
         perim_in      = PERIM_WIDTH'(sum_ff);
         ovf_in        = sat_ff;
         vcount_in     = count_ff;
         first_x_in    = '0;
         first_y_in    = '0;
         prev_x_in     = '0;
         prev_y_in     = '0;
         have_first_in = 1'b0;
         sum_in        = '0;
         sat_in        = 1'b0;
         count_in      = '0;
      end
   end

   // Polygon state.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_first_ff <= 1'b0;
         sum_ff        <= '0;
         sat_ff        <= 1'b0;
         count_ff      <= '0;
      end else begin
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         have_first_ff <= have_first_in;
         sum_ff        <= sum_in;
         sat_ff        <= sat_in;
         count_ff      <= count_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      a_x_ff    <= a_x_in;
      a_y_ff    <= a_y_in;
      b_x_ff    <= b_x_in;
      b_y_ff    <= b_y_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      perim_ff  <= perim_in;
      ovf_ff    <= ovf_in;
      vcount_ff <= vcount_in;
   end

endmodule
`default_nettype wire

@@ sv/polygon_perimeter_accumulator.sv @@
`default_nettype none
// Polygon perimeter accumulator. Vertices arrive as signed Q11.4 coordinates
// (req_mode low); a transfer with req_mode high closes the polygon, adds the
// edge back to the first vertex and returns one result: the perimeter in
// units of 1/256 (saturating, with rsp_overflow set if it saturated), and the
// number of vertices, after which all state is cleared. Items are handled one
// at a time. A vertex after the first of a polygon passes through capture,
// difference, squaring, radicand, 21 iterations of the bit-serial square root
// (one result bit a cycle) and accumulation; the first vertex is only
// captured. A close runs the same steps for the edge back to the first vertex
// when a vertex is held, and then waits while an earlier result is still
// waiting to be taken. The result sits in an output register, so the next
// item can be taken while it waits.
module polygon_perimeter_accumulator (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_mode,
   input  wire logic signed [ppa_pkg::COORD_WIDTH-1:0]  req_coord_x,
   input  wire logic signed [ppa_pkg::COORD_WIDTH-1:0]  req_coord_y,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [ppa_pkg::PERIM_WIDTH-1:0]              rsp_perimeter,
   output logic                                         rsp_overflow,
   output logic [ppa_pkg::COUNT_WIDTH-1:0]              rsp_vertex_count
);
   import ppa_pkg::*;

   ppa_cmd_type    cmd;
   ppa_status_type status;

   // Sequencing of each item.
   ppa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Polygon state, edge length unit and result register.
   ppa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_perimeter    (rsp_perimeter),
      .rsp_overflow     (rsp_overflow),
      .rsp_vertex_count (rsp_vertex_count)
   );

endmodule
`default_nettype wire

@@ sv/ppa_checker.sv @@
`default_nettype none
module ppa_checker (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   input  wire logic                                    req_ready,
   input  wire logic                                    req_mode,
   input  wire logic                                    rsp_valid,
   input  wire logic                                    rsp_ready,
   input  wire logic [ppa_pkg::PERIM_WIDTH-1:0]         rsp_perimeter,
   input  wire logic                                    rsp_overflow,
   input  wire logic [ppa_pkg::COUNT_WIDTH-1:0]         rsp_vertex_count
);
   import ppa_pkg::*;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_perimeter)
         && $stable(rsp_overflow) && $stable(rsp_vertex_count))
      else $error("stalled result changed");

   // A close transfer always leaves the block not ready straight after it.
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_CLOSE |=> !req_ready)
      else $error("ready straight after a close transfer");

   // A saturated perimeter reads as full scale.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_perimeter == {PERIM_WIDTH{1'b1}})
      else $error("overflow flagged without full scale perimeter");

   // An empty polygon has no length.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vertex_count == '0 |-> rsp_perimeter == '0 && !rsp_overflow)
      else $error("empty polygon with non-zero perimeter");

   // Nothing is offered straight after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind polygon_perimeter_accumulator ppa_checker u_ppa_checker (.*);
`default_nettype wire
